/* rtl/pbb_pkg.sv */
package pbb_pkg;

  localparam int PAL_ENTRIES  = 32768;
  localparam int PAL_AW       = $clog2(PAL_ENTRIES);
  localparam int FRAME_PIXELS = 262144;
  localparam int FS_AW        = $clog2(FRAME_PIXELS);
  localparam int BANK_DEPTH   = FRAME_PIXELS / 2;
  localparam int BANK_AW      = FS_AW - 1;
  localparam int MAX_LINE     = 512;
  localparam int POS_W        = $clog2(MAX_LINE);

  localparam int IDX_W  = 15;
  localparam int RGB_W  = 24;
  localparam int PIX_W  = 32;
  localparam int DIM_W  = 10;
  localparam int CFG_AW = 2;

  // Depth of the request queue and of the result buffer.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [PIX_W-1:0] AVG_MASK     = 32'h0101_0101;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hff;

  typedef enum logic {
    OP_PIXEL     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_BLEND  = 2'd0,
    REG_BLEED  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic blend;
    logic bleed;
    logic restart;
  } ctrl_t;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [FS_AW-1:0] addr;
    logic             line_end;
    logic             frame_end;
    logic             first;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_end;
    logic             frame_end;
  } res_t;

endpackage

/* rtl/pbb_if.sv */
interface pbb_in_if;
  import pbb_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] color_index;
  logic [RGB_W-1:0] palette_rgb;

  modport source (output valid, operation, color_index, palette_rgb, input ready);
  modport sink   (input valid, operation, color_index, palette_rgb, output ready);
endinterface

interface pbb_out_if;
  import pbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             line_end;
  logic             frame_end;

  modport source (output valid, pixel_out, line_end, frame_end, input ready);
  modport sink   (input valid, pixel_out, line_end, frame_end, output ready);
endinterface

interface pbb_cfg_if;
  import pbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [DIM_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/palette_blend_bleed_pixel_stage.sv */
// Palette lookup with frame blending and color bleed. Requests enter at one
// per clock while the queue has room, palette writes and pixels alike; with
// bleed on, a pixel's result waits for the next pixel of its line, so the
// last pixel of a line releases two results. While results are taken, the
// sustained rate of one pixel per clock is set by the single palette port
// in the front and by the frame store, split into even and odd banks with
// one write port each, in the back; a four-entry queue between them lets
// either side stall. After reset or a change of line width or frame height
// the first frame reads the frame store as zero, so there is no clearing
// pass and the block takes requests from the first cycle after reset.
module palette_blend_bleed_pixel_stage
  import pbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pbb_in_if.sink    req_i,
  pbb_out_if.source res_o,
  pbb_cfg_if.sink   cfg_i
);

  ctrl_t        ctrl;
  logic         push, pop;
  item_t        push_item, head_item;
  logic [QAW:0] q_count;

  pbb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_i     (cfg_i),
    .q_count_i (q_count),
    .ctrl_o    (ctrl),
    .push_o    (push),
    .item_o    (push_item)
  );

  pbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .count_o (q_count)
  );

  pbb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .q_count_i (q_count),
    .item_i    (head_item),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

/* rtl/pbb_front.sv */
module pbb_front
  import pbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pbb_in_if.sink       req_i,
  pbb_cfg_if.sink      cfg_i,
  input  logic [QAW:0] q_count_i,
  output ctrl_t        ctrl_o,
  output logic         push_o,
  output item_t        item_o
);

  // Last valid position for a dimension register; zero acts as one and
  // anything above the maximum line acts as the maximum.
  function automatic logic [POS_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_LINE)) begin
      r = POS_W'(MAX_LINE - 1);
    end else begin
      r = POS_W'(v - DIM_W'(1));
    end
    return r;
  endfunction

  logic             blend_q, bleed_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [POS_W-1:0] col_q, row_q;
  logic [FS_AW-1:0] addr_q;
  logic             first_q;

  logic [RGB_W-1:0] palette [PAL_ENTRIES];
  logic [RGB_W-1:0] pal_rd_q;

  logic             s1_valid_q;
  logic [FS_AW-1:0] s1_addr_q;
  logic             s1_le_q, s1_fe_q, s1_first_q;

  logic              cfg_we, restart, accept, is_pix, last_col, last_row;
  logic [POS_W-1:0]  col_last, row_last;
  logic [PAL_AW-1:0] pidx;
  logic [QAW+1:0]    in_flight;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WIDTH:  restart = (cfg_i.data != width_q);
        REG_HEIGHT: restart = (cfg_i.data != height_q);
        REG_BLEND,
        REG_BLEED:  restart = 1'b0;
      endcase
    end
  end

  // The queue slot for an item in the lookup stage is reserved at accept.
  assign in_flight   = (QAW+2)'(q_count_i) + (QAW+2)'(s1_valid_q);
  assign req_i.ready = (in_flight < (QAW+2)'(QDEPTH));
  assign accept      = req_i.valid & req_i.ready;
  assign is_pix      = (op_e'(req_i.operation) == OP_PIXEL);
  assign pidx        = req_i.color_index[PAL_AW-1:0];

  assign col_last = dim_last(width_q);
  assign row_last = dim_last(height_q);
  assign last_col = (col_q == col_last);
  assign last_row = (row_q == row_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q  <= 1'b0;
      bleed_q  <= 1'b0;
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(224);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_BLEND:  blend_q  <= cfg_i.data[0];
        REG_BLEED:  bleed_q  <= cfg_i.data[0];
        REG_WIDTH:  width_q  <= cfg_i.data;
        REG_HEIGHT: height_q <= cfg_i.data;
      endcase
    end
  end

  // Raster position. The store address runs sequentially through a frame.
  // Until the first full frame after a restart has gone by, nothing read
  // from the frame store has been written yet and it reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      addr_q     <= '0;
      first_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept & is_pix;
      if (restart) begin
        col_q   <= '0;
        row_q   <= '0;
        addr_q  <= '0;
        first_q <= 1'b1;
      end else if (accept && is_pix) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + POS_W'(1);
        end else begin
          col_q <= col_q + POS_W'(1);
        end
        if (last_col && last_row) begin
          addr_q  <= '0;
          first_q <= 1'b0;
        end else begin
          addr_q <= addr_q + FS_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (is_pix) begin
        pal_rd_q <= palette[pidx];
      end else begin
        palette[pidx] <= req_i.palette_rgb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pix) begin
      s1_addr_q  <= addr_q;
      s1_le_q    <= last_col;
      s1_fe_q    <= last_col & last_row;
      s1_first_q <= first_q;
    end
  end

  assign push_o = s1_valid_q;
  assign item_o = '{rgb:       pal_rd_q,
                    addr:      s1_addr_q,
                    line_end:  s1_le_q,
                    frame_end: s1_fe_q,
                    first:     s1_first_q};

  assign ctrl_o = '{blend: blend_q, bleed: bleed_q, restart: restart};

endmodule

/* rtl/pbb_queue.sv */
module pbb_queue
  import pbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  item_t        item_i,
  input  logic         pop_i,
  output item_t        item_o,
  output logic [QAW:0] count_o
);

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] head_q, tail_q;
  logic [QAW:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) tail_q <= tail_q + QAW'(1);
      if (pop_i)  head_q <= head_q + QAW'(1);
      count_q <= count_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[tail_q] <= item_i;
  end

  assign item_o  = mem_q[head_q];
  assign count_o = count_q;

endmodule

/* rtl/pbb_back.sv */
module pbb_back
  import pbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctrl_t        ctrl_i,
  input  logic [QAW:0] q_count_i,
  input  item_t        item_i,
  output logic         pop_o,
  pbb_out_if.source    res_o
);

  function automatic logic [PIX_W-1:0] avg32(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] s;
    s = a + b - ((a ^ b) & AVG_MASK);
    return s >> 1;
  endfunction

  // Frame store split by address parity: a pending pixel and the pixel that
  // completes it sit at neighboring addresses, so both land in one cycle.
  logic [PIX_W-1:0] bank_even [BANK_DEPTH];
  logic [PIX_W-1:0] bank_odd  [BANK_DEPTH];
  logic [PIX_W-1:0] rd_even_q, rd_odd_q;

  logic             b2_valid_q;
  item_t            b2_q;
  logic             fwd_valid_q;
  logic [PIX_W-1:0] fwd_data_q;
  logic             pend_valid_q;
  logic [PIX_W-1:0] pend_q;

  res_t           ofifo_q [QDEPTH];
  logic [QAW-1:0] ohead_q, otail_q;
  logic [QAW:0]   ocount_q;

  logic               fire, hold, wr_p, wr_c, hit_p, hit_c, opop;
  logic [PIX_W-1:0]   base, prev, c_pix, p_pix;
  logic [FS_AW-1:0]   addr_c, addr_p;
  logic               we_even, we_odd, sel_p_even, sel_p_odd;
  logic [BANK_AW-1:0] widx_even, widx_odd, rd_idx;
  logic [PIX_W-1:0]   wd_even, wd_odd;
  res_t               res_c, res_p, first_res;
  logic [QAW:0]       n_push;

  assign fire  = b2_valid_q & (ocount_q <= (QAW+1)'(QDEPTH - 2));
  assign pop_o = (q_count_i != '0) & (!b2_valid_q | fire);

  assign base = {ALPHA_OPAQUE, b2_q.rgb};

  always_comb begin
    if (b2_q.first) begin
      prev = '0;
    end else if (fwd_valid_q) begin
      prev = fwd_data_q;
    end else begin
      prev = b2_q.addr[0] ? rd_odd_q : rd_even_q;
    end
  end

  assign c_pix  = ctrl_i.blend ? avg32(prev, base) : base;
  assign p_pix  = avg32(pend_q, c_pix);
  assign hold   = ctrl_i.bleed & ~b2_q.line_end;
  assign wr_p   = fire & pend_valid_q;
  assign wr_c   = fire & ~hold;
  assign addr_c = b2_q.addr;
  assign addr_p = b2_q.addr - FS_AW'(1);

  // Writes of this cycle are invisible to a read issued in the same cycle.
  assign hit_p = wr_p & (addr_p == item_i.addr);
  assign hit_c = wr_c & (addr_c == item_i.addr);

  assign sel_p_even = wr_p & ~addr_p[0];
  assign sel_p_odd  = wr_p &  addr_p[0];
  assign we_even    = sel_p_even | (wr_c & ~addr_c[0]);
  assign we_odd     = sel_p_odd  | (wr_c &  addr_c[0]);
  assign widx_even  = sel_p_even ? addr_p[FS_AW-1:1] : addr_c[FS_AW-1:1];
  assign widx_odd   = sel_p_odd  ? addr_p[FS_AW-1:1] : addr_c[FS_AW-1:1];
  assign wd_even    = sel_p_even ? p_pix : c_pix;
  assign wd_odd     = sel_p_odd  ? p_pix : c_pix;
  assign rd_idx     = item_i.addr[FS_AW-1:1];

  always_ff @(posedge clk_i) begin
    if (pop_o)   rd_even_q <= bank_even[rd_idx];
    if (we_even) bank_even[widx_even] <= wd_even;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o)  rd_odd_q <= bank_odd[rd_idx];
    if (we_odd) bank_odd[widx_odd] <= wd_odd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b2_valid_q  <= 1'b1;
        fwd_valid_q <= hit_p | hit_c;
      end else if (fire) begin
        b2_valid_q <= 1'b0;
      end
      if (ctrl_i.restart) begin
        pend_valid_q <= 1'b0;
      end else if (fire) begin
        pend_valid_q <= hold;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b2_q       <= item_i;
      fwd_data_q <= hit_c ? c_pix : p_pix;
    end
    if (fire && hold) pend_q <= c_pix;
  end

  // Result buffer: up to two results enter per cycle, and at most one leaves.
  assign res_c     = '{pixel: c_pix, line_end: b2_q.line_end, frame_end: b2_q.frame_end};
  assign res_p     = '{pixel: p_pix, line_end: 1'b0, frame_end: 1'b0};
  assign first_res = wr_p ? res_p : res_c;
  assign n_push    = (QAW+1)'(wr_p) + (QAW+1)'(wr_c);
  assign opop      = res_o.valid & res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ohead_q  <= '0;
      otail_q  <= '0;
      ocount_q <= '0;
    end else begin
      otail_q  <= otail_q + n_push[QAW-1:0];
      if (opop) ohead_q <= ohead_q + QAW'(1);
      ocount_q <= ocount_q + n_push - (QAW+1)'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_p | wr_c)  ofifo_q[otail_q] <= first_res;
    if (wr_p && wr_c) ofifo_q[otail_q + QAW'(1)] <= res_c;
  end

  assign res_o.valid     = (ocount_q != '0);
  assign res_o.pixel_out = ofifo_q[ohead_q].pixel;
  assign res_o.line_end  = ofifo_q[ohead_q].line_end;
  assign res_o.frame_end = ofifo_q[ohead_q].frame_end;

endmodule

/* rtl/pbb_checker.sv */
module pbb_checker
  import pbb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [PIX_W-1:0] res_pixel_i,
  input logic             res_line_end_i,
  input logic             res_frame_end_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_pixel_i) &&
      $stable(res_line_end_i) && $stable(res_frame_end_i))
    else $error("stalled result changed or was dropped");

  a_frame_end_on_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_frame_end_i |-> res_line_end_i)
    else $error("frame end flagged on a pixel that does not end a line");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result offered during reset");

endmodule

bind palette_blend_bleed_pixel_stage pbb_checker u_pbb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_pixel_i     (res_o.pixel_out),
  .res_line_end_i  (res_o.line_end),
  .res_frame_end_i (res_o.frame_end)
);

/* tb/palette_blend_bleed_pixel_stage_tb.sv */
`timescale 1ns / 100ps

module palette_blend_bleed_pixel_stage_tb;
  import pbb_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 850;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
  } pixel_request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  pbb_in_if  req_if ();
  pbb_out_if res_if ();
  pbb_cfg_if cfg_if ();

  palette_blend_bleed_pixel_stage i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Requests waiting to be offered, and the one currently on the channel.
  pixel_request_t request_q [$];
  pixel_request_t cur_req;
  bit             req_busy;

  // Results the block owes, oldest first.
  res_t expected_pixels [$];

  // Predictor state.
  logic [RGB_W-1:0] palette_mem [PAL_ENTRIES];
  logic [PIX_W-1:0] frame_mem [FRAME_PIXELS];
  logic [PIX_W-1:0] held_pixel;
  bit               held_valid;
  int unsigned      column;
  int unsigned      line_no;
  logic             pred_blend;
  logic             pred_bleed;
  logic [DIM_W-1:0] pred_width;
  logic [DIM_W-1:0] pred_height;

  // Palette entries the stimulus has loaded; pixels only point at these.
  logic [IDX_W-1:0] loaded_idx [$];

  int send_idle_pct = 28;
  int recv_idle_pct = 67;
  int hold_left     = 0;
  int err_count     = 0;

  function automatic logic [PIX_W-1:0] mean_rgba(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] s;
    s = a + b - ((a ^ b) & AVG_MASK);
    return s >> 1;
  endfunction

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_LINE) return MAX_LINE;
    return v;
  endfunction

  function automatic int unsigned fs_addr(input int unsigned row, input int unsigned col,
                                          input int unsigned w);
    return (row * w + col) % FRAME_PIXELS;
  endfunction

  task automatic restart_frame();
    foreach (frame_mem[i]) frame_mem[i] = '0;
    held_pixel = '0;
    held_valid = 1'b0;
    column     = 0;
    line_no    = 0;
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic predict_pixels(input pixel_request_t r);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    int unsigned      addr;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] p;
    logic             le;
    logic             fe;
    if (r.op == OP_PAL_WRITE) begin
      palette_mem[r.idx] = r.rgb;
      return;
    end
    w   = clamp_dim(pred_width);
    h   = clamp_dim(pred_height);
    col = (column >= w) ? w - 1 : column;
    row = (line_no >= h) ? h - 1 : line_no;
    addr = fs_addr(row, col, w);
    c = {ALPHA_OPAQUE, palette_mem[r.idx]};
    if (pred_blend) c = mean_rgba(frame_mem[addr], c);
    le = (col == w - 1);
    fe = le && (row == h - 1);
    // Unless a restart drops it, a held pixel is finished by the next one, whatever bleed is now.
    if (held_valid) begin
      p = mean_rgba(held_pixel, c);
      frame_mem[fs_addr(row, (col == 0) ? 0 : col - 1, w)] = p;
      expected_pixels.push_back('{pixel: p, line_end: 1'b0, frame_end: 1'b0});
      held_valid = 1'b0;
      held_pixel = '0;
    end
    if (pred_bleed && !le) begin
      held_pixel = c;
      held_valid = 1'b1;
    end else begin
      frame_mem[addr] = c;
      expected_pixels.push_back('{pixel: c, line_end: le, frame_end: fe});
    end
    if (le) begin
      column  = 0;
      line_no = fe ? 0 : row + 1;
    end else begin
      column  = col + 1;
      line_no = row;
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_busy = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_pixels(cur_req);
        req_busy = 1'b0;
      end
      if (!req_busy && request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req  = request_q.pop_front();
        req_busy = 1'b1;
      end
      req_if.valid       <= req_busy;
      req_if.operation   <= cur_req.op;
      req_if.color_index <= cur_req.idx;
      req_if.palette_rgb <= cur_req.rgb;
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_res;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected result pixel %h line_end %b frame_end %b",
                               res_if.pixel_out, res_if.line_end, res_if.frame_end));
        end else begin
          exp_res = expected_pixels.pop_front();
          if (res_if.pixel_out !== exp_res.pixel || res_if.line_end !== exp_res.line_end ||
              res_if.frame_end !== exp_res.frame_end)
            flag_error($sformatf("expected pixel %h le %b fe %b, got pixel %h le %b fe %b",
                                 exp_res.pixel, exp_res.line_end, exp_res.frame_end,
                                 res_if.pixel_out, res_if.line_end, res_if.frame_end));
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Counts down a long hold-off of the result side.
  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic push_write(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
    request_q.push_back('{op: OP_PAL_WRITE, idx: idx, rgb: rgb});
    loaded_idx.push_back(idx);
  endtask

  task automatic push_pixel(input logic [IDX_W-1:0] idx);
    request_q.push_back('{op: OP_PIXEL, idx: idx, rgb: RGB_W'($urandom)});
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned common_max);
    case ($urandom_range(19))
      0:       return '0;
      1:       return DIM_W'(MAX_LINE);
      2:       return '1;
      3:       return DIM_W'($urandom_range(1, MAX_LINE));
      default: return DIM_W'($urandom_range(1, common_max));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_BLEND: pred_blend = val[0];
      REG_BLEED: pred_bleed = val[0];
      REG_WIDTH: begin
        if (val != pred_width) begin
          pred_width = val;
          restart_frame();
        end
      end
      REG_HEIGHT: begin
        if (val != pred_height) begin
          pred_height = val;
          restart_frame();
        end
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || req_busy || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned      n_random;
    int unsigned      len;
    int unsigned      phase_no;
    logic [DIM_W-1:0] width_val;
    logic [DIM_W-1:0] height_val;
    logic [IDX_W-1:0] mid_idx;

    // The falling edge lands after every process waits on it, so the
    // asynchronous reset takes hold at time zero.
    rst_ni             <= 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_PIXEL;
    req_if.color_index = '0;
    req_if.palette_rgb = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_BLEND;
    cfg_if.data        = '0;
    cur_req            = '0;
    pred_blend         = 1'b0;
    pred_bleed         = 1'b0;
    pred_width         = DIM_W'(256);
    pred_height        = DIM_W'(224);
    restart_frame();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Plain lookup over one 3x2 frame, palette extremes included.
    write_reg(REG_BLEND, 0);
    write_reg(REG_BLEED, 0);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    mid_idx = IDX_W'($urandom);
    push_write('0, '0);
    push_write('1, '1);
    push_write(mid_idx, RGB_W'($urandom));
    push_write(IDX_W'($urandom), RGB_W'($urandom));
    push_pixel('0);
    push_pixel('1);
    push_pixel(mid_idx);
    push_pixel('0);
    push_pixel('1);
    push_pixel(mid_idx);
    wait_drained();

    // Same frame again, blended with the stored one and bled to the right.
    write_reg(REG_BLEND, 1);
    write_reg(REG_BLEED, 1);
    push_pixel('1);
    push_pixel('0);
    push_pixel(mid_idx);
    push_pixel('1);
    push_pixel('0);
    push_pixel(mid_idx);
    wait_drained();

    // Bleed turned off while a pixel is held; rewriting the same width keeps it.
    push_pixel(mid_idx);
    wait_drained();
    write_reg(REG_BLEED, 0);
    write_reg(REG_WIDTH, 3);
    push_pixel('1);
    push_pixel('0);
    wait_drained();

    // A real dimension change drops the held pixel; zero and oversize dimensions.
    write_reg(REG_BLEED, 1);
    push_pixel('1);
    wait_drained();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, '1);
    push_pixel(mid_idx);
    push_pixel('0);
    push_pixel('1);
    wait_drained();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_BLEND, 0);
    push_pixel('1);
    push_pixel(mid_idx);
    wait_drained();

    n_random   = 0;
    phase_no   = 0;
    width_val  = 1;
    height_val = 1;
    while (n_random < RANDOM_ITEMS) begin
      if (n_random >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_random >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 28;
      end
      wait_drained();
      if ($urandom_range(9) < 6) begin
        width_val  = pick_dim(8);
        height_val = pick_dim(4);
      end
      write_reg(REG_BLEND, $urandom_range(1));
      write_reg(REG_BLEED, $urandom_range(1));
      write_reg(REG_WIDTH, width_val);
      write_reg(REG_HEIGHT, height_val);
      len = (clamp_dim(width_val) > 16) ? 120 : $urandom_range(30, 90);
      // Stall the result side for a long while so the input backs up.
      if (phase_no == 2) hold_left = 300;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(4) == 0) push_write(IDX_W'($urandom), RGB_W'($urandom));
        else push_pixel(pick_index());
      end
      n_random += len;
      phase_no++;
    end

    while (request_q.size() != 0 || req_busy) @(negedge clk_i);
    for (int k = 0; k < DRAIN_LIMIT && expected_pixels.size() != 0; k++) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_pixels.size()));

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* palette_blend_bleed_pixel_stage.f */
rtl/pbb_pkg.sv
rtl/pbb_if.sv
rtl/pbb_front.sv
rtl/pbb_queue.sv
rtl/pbb_back.sv
rtl/palette_blend_bleed_pixel_stage.sv
rtl/pbb_checker.sv
tb/palette_blend_bleed_pixel_stage_tb.sv
